/* sv/btb2l_pkg.sv */
// -----------------------------------------------------------------------------
// btb2l_pkg
// Shared types and codes for the two-level branch predictor with BTB.
// -----------------------------------------------------------------------------
package btb2l_pkg;

   // command codes
   localparam logic CMD_PREDICT = 1'b0;
   localparam logic CMD_UPDATE  = 1'b1;

   // counter index sharing modes
   localparam logic [1:0] SHARE_NONE = 2'd0;
   localparam logic [1:0] SHARE_PC2  = 2'd1;
   localparam logic [1:0] SHARE_PC16 = 2'd2;

   // index width limit and tag span
   localparam logic [2:0] INDEX_BITS_MAX = 3'd5;
   localparam logic [4:0] TAG_SPAN       = 5'd30;

   // register map, one word apart
   typedef enum logic [2:0] {
      REG_INDEX_BITS     = 3'd0,
      REG_HISTORY_LENGTH = 3'd1,
      REG_TAG_LENGTH     = 3'd2,
      REG_INITIAL_CTR    = 3'd3,
      REG_GLOBAL_HISTORY = 3'd4,
      REG_GLOBAL_TABLE   = 3'd5,
      REG_SHARE_MODE     = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic        command;
      logic [31:0] pc;
      logic [31:0] resolved_target;
      logic        outcome_taken;
      logic [31:0] earlier_prediction;
   } req_type;

   typedef struct packed {
      logic        predict_taken;
      logic [31:0] predicted_target;
      logic [31:0] branch_count;
      logic [31:0] flush_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_READ,
      ST_EXEC
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic sweep_clr;
      logic init_wr;
      logic decode;
      logic row_wr;
      logic rd;
      logic exec;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cfg_written;
      logic init_last;
      logic row_last;
      logic need_row_clear;
   } dp_sts_type;

endpackage

/* sv/btb2l_ctrl.sv */
// -----------------------------------------------------------------------------
// btb2l_ctrl
// Sequencer: clearing pass, decode, row clear, counter read, execute.
// -----------------------------------------------------------------------------
module btb2l_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  btb2l_pkg::dp_sts_type sts,
   output btb2l_pkg::ctl_cmd_type cmd
);
   import btb2l_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_INIT: begin
            if (sts.cfg_written) begin
               cmd.sweep_clr = 1'b1;
            end else begin
               cmd.init_wr = 1'b1;
               if (sts.init_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (sts.cfg_written) begin
               cmd.sweep_clr = 1'b1;
               state_in      = ST_INIT;
            end else if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode    = 1'b1;
            cmd.sweep_clr = 1'b1;
            state_in      = sts.need_row_clear ? ST_CLEAR : ST_READ;
         end
         ST_CLEAR: begin
            cmd.row_wr = 1'b1;
            if (sts.row_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

/* sv/btb2l_dpath.sv */
// -----------------------------------------------------------------------------
// btb2l_dpath
// Registers, BTB entries, histories, counter memories and result register.
// -----------------------------------------------------------------------------
module btb2l_dpath #(
   parameter int BTB_ENTRIES = 32,
   parameter int HISTORY_MAX = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  btb2l_pkg::ctl_cmd_type cmd,
   output btb2l_pkg::dp_sts_type  sts,
   input  btb2l_pkg::req_type     req_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [4:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   rsp_strobe,
   output btb2l_pkg::rsp_type     rsp_data
);
   import btb2l_pkg::*;

   localparam int EW          = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
   localparam int HM          = HISTORY_MAX;
   localparam int CTR_DEPTH   = 1 << HISTORY_MAX;
   localparam int LOCAL_DEPTH = BTB_ENTRIES * CTR_DEPTH;
   localparam int LW          = EW + HM;

   // ---------------- configuration registers ----------------
   logic [2:0] index_bits_ff;
   logic [3:0] history_length_ff;
   logic [4:0] tag_length_ff;
   logic [1:0] initial_ctr_ff;
   logic       global_history_ff;
   logic       global_table_ff;
   logic [1:0] share_mode_ff;
   logic       csr_wr;
   logic       cfg_hit;

   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff     <= 3'd0;
         history_length_ff <= 4'd1;
         tag_length_ff     <= 5'd0;
         initial_ctr_ff    <= 2'd1;
         global_history_ff <= 1'b0;
         global_table_ff   <= 1'b0;
         share_mode_ff     <= 2'd0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_INDEX_BITS:     index_bits_ff     <= csr_pwdata[2:0];
            REG_HISTORY_LENGTH: history_length_ff <= csr_pwdata[3:0];
            REG_TAG_LENGTH:     tag_length_ff     <= csr_pwdata[4:0];
            REG_INITIAL_CTR:    initial_ctr_ff    <= csr_pwdata[1:0];
            REG_GLOBAL_HISTORY: global_history_ff <= csr_pwdata[0];
            REG_GLOBAL_TABLE:   global_table_ff   <= csr_pwdata[0];
            REG_SHARE_MODE:     share_mode_ff     <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   // writes beyond the map are dropped and do not restart the clearing pass
   always_comb begin
      cfg_hit    = 1'b1;
      csr_prdata = '0;
      unique case (csr_paddr[4:2])
         REG_INDEX_BITS:     csr_prdata = {29'd0, index_bits_ff};
         REG_HISTORY_LENGTH: csr_prdata = {28'd0, history_length_ff};
         REG_TAG_LENGTH:     csr_prdata = {27'd0, tag_length_ff};
         REG_INITIAL_CTR:    csr_prdata = {30'd0, initial_ctr_ff};
         REG_GLOBAL_HISTORY: csr_prdata = {31'd0, global_history_ff};
         REG_GLOBAL_TABLE:   csr_prdata = {31'd0, global_table_ff};
         REG_SHARE_MODE:     csr_prdata = {30'd0, share_mode_ff};
         default:            cfg_hit    = 1'b0;
      endcase
   end

   assign sts.cfg_written = csr_wr & cfg_hit;

   // ---------------- request register ----------------
   req_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // ---------------- field decode ----------------
   logic [2:0]    ib;
   logic [4:0]    idx5;
   logic [5:0]    imask;
   logic [EW-1:0] mod_tab [32];
   logic [EW-1:0] entry;
   logic [4:0]    tag_room;
   logic [4:0]    tu;
   logic [30:0]   tmask;
   logic [31:0]   pc_shift;
   logic [29:0]   tag;
   logic [3:0]    hu;
   logic [HM:0]   hmask_w;
   logic [HM-1:0] hmask;

   // entry index reduced modulo the entry count, a constant table
   for (genvar gi = 0; gi < 32; gi++) begin : g_mod
      assign mod_tab[gi] = EW'(gi % BTB_ENTRIES);
   end

   always_comb begin
      ib       = (index_bits_ff > INDEX_BITS_MAX) ? INDEX_BITS_MAX : index_bits_ff;
      imask    = (6'd1 << ib) - 6'd1;
      idx5     = req_ff.pc[6:2] & imask[4:0];
      entry    = mod_tab[idx5];
      tag_room = TAG_SPAN - {2'd0, ib};
      tu       = (tag_length_ff > tag_room) ? tag_room : tag_length_ff;
      tmask    = (31'd1 << tu) - 31'd1;
      pc_shift = req_ff.pc >> ({29'd0, ib} + 32'd2);
      tag      = pc_shift[29:0] & tmask[29:0];
      if (history_length_ff < 4'd1) begin
         hu = 4'd1;
      end else if (history_length_ff > 4'(HISTORY_MAX)) begin
         hu = 4'(HISTORY_MAX);
      end else begin
         hu = history_length_ff;
      end
      hmask_w = ((HM+1)'(1) << hu) - (HM+1)'(1);
      hmask   = hmask_w[HM-1:0];
   end

   // ---------------- BTB entries and histories ----------------
   logic          valid_ff [BTB_ENTRIES];
   logic [29:0]   tag_mem  [BTB_ENTRIES];
   logic [31:0]   tgt_mem  [BTB_ENTRIES];
   logic [HM-1:0] lhist_ff [BTB_ENTRIES];
   logic [HM-1:0] ghist_ff;
   logic [EW-1:0] e_ff;
   logic [29:0]   tag_ff;
   logic          hit_ff;
   logic          replace;

   assign replace            = valid_ff[entry] && (tag_mem[entry] != tag)
                               && (req_ff.command == CMD_UPDATE);
   assign sts.need_row_clear = replace && !global_table_ff;

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         e_ff   <= entry;
         tag_ff <= tag;
         hit_ff <= valid_ff[entry] && (tag_mem[entry] == tag);
      end
   end

   // ---------------- counter index ----------------
   logic [31:0]   sh;
   logic [HM-1:0] hsel;
   logic [HM-1:0] ci;
   logic [HM-1:0] ci_ff;

   always_comb begin
      case (share_mode_ff)
         SHARE_PC2:  sh = req_ff.pc >> 2;
         SHARE_PC16: sh = req_ff.pc >> 16;
         default:    sh = 32'd0;
      endcase
      hsel = global_history_ff ? ghist_ff : lhist_ff[e_ff];
      ci   = (hsel ^ sh[HM-1:0]) & hmask;
   end

   // ---------------- sweep counter ----------------
   logic [LW-1:0] sweep_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_clr) begin
         sweep_ff <= '0;
      end else if (cmd.init_wr || cmd.row_wr) begin
         sweep_ff <= sweep_ff + LW'(1);
      end
   end

   assign sts.init_last = (sweep_ff == LW'(LOCAL_DEPTH - 1));
   assign sts.row_last  = (sweep_ff[HM-1:0] == {HM{1'b1}});

   // ---------------- counter memories ----------------
   logic [1:0]    lmem [LOCAL_DEPTH];
   logic [1:0]    smem [CTR_DEPTH];
   logic [1:0]    lrd_ff;
   logic [1:0]    srd_ff;
   logic [1:0]    ctr;
   logic [1:0]    ctr_new;
   logic          l_we;
   logic [LW-1:0] l_wa;
   logic [1:0]    l_wd;
   logic          s_we;
   logic [HM-1:0] s_wa;
   logic [1:0]    s_wd;
   logic          is_upd;

   assign is_upd = (req_ff.command == CMD_UPDATE);
   assign ctr    = global_table_ff ? srd_ff : lrd_ff;

   always_comb begin
      if (req_ff.outcome_taken) begin
         ctr_new = (ctr < 2'd3) ? ctr + 2'd1 : ctr;
      end else begin
         ctr_new = (ctr > 2'd0) ? ctr - 2'd1 : ctr;
      end
   end

   // write port selection: clearing pass, row clear or training
   always_comb begin
      l_we = 1'b0;
      l_wa = sweep_ff;
      l_wd = initial_ctr_ff;
      s_we = 1'b0;
      s_wa = sweep_ff[HM-1:0];
      s_wd = initial_ctr_ff;
      if (cmd.init_wr) begin
         l_we = 1'b1;
         s_we = 1'b1;
      end else if (cmd.row_wr) begin
         l_we = 1'b1;
         l_wa = {e_ff, sweep_ff[HM-1:0]};
      end else if (cmd.exec && is_upd) begin
         l_we = !global_table_ff;
         l_wa = {e_ff, ci_ff};
         l_wd = ctr_new;
         s_we = global_table_ff;
         s_wa = ci_ff;
         s_wd = ctr_new;
      end
   end

   always_ff @(posedge clock) begin
      if (l_we) begin
         lmem[l_wa] <= l_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         smem[s_wa] <= s_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         lrd_ff <= lmem[{e_ff, ci}];
         srd_ff <= smem[ci];
         ci_ff  <= ci;
      end
   end

   // ---------------- entry state updates ----------------
   logic [HM-1:0] hsh;
   assign hsh = HM'({hsel, req_ff.outcome_taken}) & hmask;

   always_ff @(posedge clock) begin
      if (reset || cmd.init_wr) begin
         for (int i = 0; i < BTB_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            lhist_ff[i] <= '0;
         end
         ghist_ff <= '0;
      end else if (cmd.decode && replace && !global_history_ff) begin
         lhist_ff[entry] <= '0;
      end else if (cmd.exec && is_upd) begin
         valid_ff[e_ff] <= 1'b1;
         if (global_history_ff) begin
            ghist_ff <= hsh;
         end else begin
            lhist_ff[e_ff] <= hsh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && is_upd) begin
         tag_mem[e_ff] <= tag_ff;
         tgt_mem[e_ff] <= req_ff.resolved_target;
      end
   end

   // ---------------- counts and result ----------------
   logic [31:0] branches_ff, branches_in;
   logic [31:0] flushes_ff, flushes_in;
   logic [31:0] pc_plus4;
   logic        mispredict;
   logic        taken;

   assign pc_plus4   = req_ff.pc + 32'd4;
   assign mispredict = req_ff.outcome_taken
                       ? (req_ff.resolved_target != req_ff.earlier_prediction)
                       : (req_ff.earlier_prediction != pc_plus4);
   assign taken      = hit_ff && (ctr >= 2'd2);
   assign branches_in = branches_ff + {31'd0, !is_upd};
   assign flushes_in  = flushes_ff + {31'd0, is_upd && mispredict};

   always_ff @(posedge clock) begin
      if (reset || cmd.init_wr) begin
         branches_ff <= '0;
         flushes_ff  <= '0;
         rsp_strobe  <= 1'b0;
      end else begin
         rsp_strobe <= cmd.exec;
         if (cmd.exec) begin
            branches_ff <= branches_in;
            flushes_ff  <= flushes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_data.branch_count <= branches_in;
         rsp_data.flush_count  <= flushes_in;
         if (is_upd) begin
            rsp_data.predict_taken    <= 1'b0;
            rsp_data.predicted_target <= 32'd0;
         end else begin
            rsp_data.predict_taken    <= taken;
            rsp_data.predicted_target <= taken ? tgt_mem[e_ff] : pc_plus4;
         end
      end
   end

endmodule

/* sv/btb_two_level_branch_predictor.sv */
// -----------------------------------------------------------------------------
// btb_two_level_branch_predictor
// Direct-mapped BTB with two-level direction prediction and flush counting.
// A start is accepted while idle; the command then passes through decode, counter
// read and execute before the result strobe, and an update that replaces a tag with
// per-entry tables adds a row clear of the entry's counters. A new command is taken only once idle again.
// Reset and each register write in the map, made while idle or during the pass, run a
// clearing pass over BTB_ENTRIES*2^HISTORY_MAX counters (8192 by default) with busy high; results are never held off.
// -----------------------------------------------------------------------------
module btb_two_level_branch_predictor #(
   parameter int BTB_ENTRIES = 32,
   parameter int HISTORY_MAX = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  btb2l_pkg::req_type req_data,
   output logic               rsp_strobe,
   output btb2l_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import btb2l_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   assign csr_pready = 1'b1;

   btb2l_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   btb2l_dpath #(
      .BTB_ENTRIES (BTB_ENTRIES),
      .HISTORY_MAX (HISTORY_MAX)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

/* tb/btb_two_level_branch_predictor_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// btb_two_level_branch_predictor_tb
// Self-checking bench for the two-level branch predictor with BTB. Commands go
// in through the start/busy handshake and every result beat is compared with a
// behavioural predictor of the BTB, the histories and the counter tables. The
// run steps through several register settings, the extremes among them.
// -----------------------------------------------------------------------------
module btb_two_level_branch_predictor_tb;
   import btb2l_pkg::*;

   localparam int ENTRIES  = 32;
   localparam int CTR_ROWS = 256;
   localparam int WATCHDOG = 60000;

   // behavioural predictor and store of expected result beats
   class btb_scoreboard;
      int unsigned idx_bits, hist_len, tag_len, init_ctr, glob_hist, glob_tbl, share;
      bit          ent_valid [ENTRIES];
      logic [31:0] ent_tag [ENTRIES];
      logic [31:0] ent_tgt [ENTRIES];
      logic [7:0]  loc_hist [ENTRIES];
      logic [7:0]  shr_hist;
      logic [1:0]  shr_ctr [CTR_ROWS];
      logic [1:0]  loc_ctr [ENTRIES][CTR_ROWS];
      logic [31:0] branches, flushes;
      rsp_type     pending [$];
      int          errors;

      function new();
         idx_bits = 0; hist_len = 1; tag_len = 0; init_ctr = 1;
         glob_hist = 0; glob_tbl = 0; share = 0;
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         for (int e = 0; e < ENTRIES; e++) begin
            ent_valid[e] = 0;
            loc_hist[e] = '0;
            for (int c = 0; c < CTR_ROWS; c++) loc_ctr[e][c] = init_ctr[1:0];
         end
         for (int c = 0; c < CTR_ROWS; c++) shr_ctr[c] = init_ctr[1:0];
         shr_hist = '0;
         branches = '0;
         flushes = '0;
      endfunction

      function void set_reg(csr_reg_type r, logic [31:0] v);
         case (r)
            REG_INDEX_BITS:     idx_bits = v & 7;
            REG_HISTORY_LENGTH: hist_len = v & 15;
            REG_TAG_LENGTH:     tag_len = v & 31;
            REG_INITIAL_CTR:    init_ctr = v & 3;
            REG_GLOBAL_HISTORY: glob_hist = v & 1;
            REG_GLOBAL_TABLE:   glob_tbl = v & 1;
            REG_SHARE_MODE:     share = v & 3;
            default:            return;
         endcase
         clear_state();
      endfunction

      function int unsigned ib();
         return idx_bits > 5 ? 5 : idx_bits;
      endfunction

      function int unsigned hist_mask();
         int unsigned h;
         h = hist_len;
         if (h < 1) h = 1;
         if (h > 8) h = 8;
         return (1 << h) - 1;
      endfunction

      function int unsigned ctr_index(int unsigned e, logic [31:0] pc);
         logic [31:0] sh, hv;
         sh = '0;
         if (share == SHARE_PC2) sh = pc >> 2;
         else if (share == SHARE_PC16) sh = pc >> 16;
         hv = glob_hist ? shr_hist : loc_hist[e];
         return (hv ^ sh) & hist_mask() & 255;
      endfunction

      // works out the result beat for one accepted command
      function void note_command(req_type r);
         int unsigned e, t, ci;
         logic [31:0] tag;
         logic [1:0]  c;
         rsp_type     x;
         e = (r.pc >> 2) & ((1 << ib()) - 1);
         t = tag_len;
         if (t > 30 - ib()) t = 30 - ib();
         tag = (r.pc >> (2 + ib())) & ((32'd1 << t) - 1);
         x = '0;
         if (r.command == CMD_PREDICT) begin
            branches++;
            x.predicted_target = r.pc + 4;
            ci = ctr_index(e, r.pc);
            c = glob_tbl ? shr_ctr[ci] : loc_ctr[e][ci];
            if (ent_valid[e] && ent_tag[e] == tag && c >= 2) begin
               x.predict_taken = 1'b1;
               x.predicted_target = ent_tgt[e];
            end
         end else begin
            if ((r.outcome_taken && r.resolved_target != r.earlier_prediction) ||
                (!r.outcome_taken && r.earlier_prediction != r.pc + 4))
               flushes++;
            // tag replacement wipes the entry's own row and history where they are per-entry
            if (ent_valid[e] && ent_tag[e] != tag) begin
               if (!glob_tbl)
                  for (int k = 0; k < CTR_ROWS; k++) loc_ctr[e][k] = init_ctr[1:0];
               if (!glob_hist) loc_hist[e] = '0;
            end
            ent_valid[e] = 1;
            ent_tag[e] = tag;
            ci = ctr_index(e, r.pc);
            c = glob_tbl ? shr_ctr[ci] : loc_ctr[e][ci];
            if (r.outcome_taken) begin
               if (c < 3) c = c + 1;
            end else begin
               if (c > 0) c = c - 1;
            end
            if (glob_tbl) shr_ctr[ci] = c;
            else loc_ctr[e][ci] = c;
            if (glob_hist) shr_hist = ((shr_hist << 1) | r.outcome_taken) & hist_mask();
            else loc_hist[e] = ((loc_hist[e] << 1) | r.outcome_taken) & hist_mask();
            ent_tgt[e] = r.resolved_target;
         end
         x.branch_count = branches;
         x.flush_count = flushes;
         pending = {pending, x};
      endfunction

      function void check_beat(rsp_type a);
         rsp_type x;
         if (pending.size() == 0) begin
            $error("unexpected result beat %h", a);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (a.predict_taken !== x.predict_taken) begin
            $error("predict_taken: expected %0h actual %0h", x.predict_taken,
                   a.predict_taken);
            errors++;
         end
         if (a.predicted_target !== x.predicted_target) begin
            $error("predicted_target: expected %h actual %h", x.predicted_target,
                   a.predicted_target);
            errors++;
         end
         if (a.branch_count !== x.branch_count) begin
            $error("branch_count: expected %0d actual %0d", x.branch_count,
                   a.branch_count);
            errors++;
         end
         if (a.flush_count !== x.flush_count) begin
            $error("flush_count: expected %0d actual %0d", x.flush_count,
                   a.flush_count);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset, start, busy, rsp_strobe;
   req_type     req_data;
   rsp_type     rsp_data;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   btb_scoreboard sb;
   int          idle_cycles;
   logic [31:0] pool_pc [8];
   logic [31:0] pool_tgt [8];
   bit          pool_dir [8];

   btb_two_level_branch_predictor u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_beat(rsp_data);
         if (rsp_strobe || (start && !busy) || (csr_psel && csr_penable && csr_pwrite))
            idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("btb_two_level_branch_predictor regression: fail");
            $finish;
         end
      end
   end

   // one command beat; start stays high if the next beat follows at once
   task automatic send_beat(req_type r, bit allow_gap);
      if (allow_gap && $urandom_range(99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(r);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, then let the clearing pass finish
   task automatic csr_write(csr_reg_type r, logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(r) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(r, v);
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic req_type mk_update(logic [31:0] pc, logic [31:0] tgt, bit tk,
                                         bit right);
      req_type r;
      r.command = CMD_UPDATE;
      r.pc = pc;
      r.resolved_target = tgt;
      r.outcome_taken = tk;
      r.earlier_prediction = right ? (tk ? tgt : pc + 4) : $urandom;
      return r;
   endfunction

   function automatic req_type mk_predict(logic [31:0] pc);
      req_type r;
      r = '0;
      r.command = CMD_PREDICT;
      r.pc = pc;
      r.resolved_target = $urandom;
      r.earlier_prediction = $urandom;
      r.outcome_taken = $urandom_range(1);
      return r;
   endfunction

   // extremes, hit, miss, mispredicts and a tag replacement
   task automatic directed_beats();
      send_beat(mk_predict(32'h0), 0);
      send_beat(mk_predict(32'hFFFF_FFFF), 0);
      send_beat(mk_update(32'h0, 32'hFFFF_FFFF, 1, 1), 0);
      send_beat(mk_update(32'h0, 32'hFFFF_FFFF, 1, 0), 0);
      send_beat(mk_predict(32'h0), 0);
      send_beat(mk_update(32'hFFFF_FFFF, 32'h0, 0, 1), 0);
      send_beat(mk_update(32'hFFFF_FFFF, 32'h0, 0, 0), 0);
      send_beat(mk_predict(32'hFFFF_FFFF), 0);
      send_beat(mk_update(32'h8000_0000, 32'h1234_5678, 1, 1), 0);
      send_beat(mk_update(32'h8000_0000, 32'h1234_5678, 1, 1), 0);
      send_beat(mk_predict(32'h8000_0000), 0);
      send_beat(mk_update(32'h4000_0000, 32'hABCD_0000, 1, 0), 0);
      send_beat(mk_predict(32'h8000_0000), 0);
      send_beat(mk_predict(32'h4000_0000), 0);
   endtask

   task automatic random_beats(int n, bit allow_gap, bit hold_mid);
      req_type r;
      int      k;
      for (int i = 0; i < 8; i++) begin
         pool_pc[i] = $urandom;
         pool_tgt[i] = $urandom;
         pool_dir[i] = $urandom_range(1);
      end
      for (int i = 0; i < n; i++) begin
         if (hold_mid && i == n / 2) drain();
         k = $urandom_range(7);
         if ($urandom_range(99) < 10) begin
            r.command = $urandom_range(1);
            r.pc = $urandom;
            r.resolved_target = $urandom;
            r.outcome_taken = $urandom_range(1);
            r.earlier_prediction = $urandom;
         end else if ($urandom_range(1)) begin
            r = mk_predict(pool_pc[k]);
         end else begin
            r = mk_update(pool_pc[k],
                          $urandom_range(9) == 0 ? $urandom : pool_tgt[k],
                          $urandom_range(9) < 8 ? pool_dir[k] : !pool_dir[k],
                          $urandom_range(9) < 7);
         end
         send_beat(r, allow_gap);
      end
   endtask

   initial begin
      sb = new();
      idle_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings
      directed_beats();
      random_beats(180, 1, 1);
      drain();

      // widest index, longest history, per-entry tables
      csr_write(REG_INDEX_BITS, 32'd5);
      csr_write(REG_HISTORY_LENGTH, 32'd8);
      csr_write(REG_TAG_LENGTH, 32'd25);
      csr_write(REG_INITIAL_CTR, 32'd3);
      csr_write(REG_SHARE_MODE, 32'(SHARE_PC2));
      directed_beats();
      random_beats(200, 0, 0);
      drain();

      // global history and table, tag length beyond the span
      csr_write(REG_INDEX_BITS, 32'd3);
      csr_write(REG_HISTORY_LENGTH, 32'd4);
      csr_write(REG_TAG_LENGTH, 32'd30);
      csr_write(REG_INITIAL_CTR, 32'd0);
      csr_write(REG_GLOBAL_HISTORY, 32'd1);
      csr_write(REG_GLOBAL_TABLE, 32'd1);
      csr_write(REG_SHARE_MODE, 32'(SHARE_PC16));
      directed_beats();
      random_beats(200, 1, 0);
      drain();

      // out of range values saturate, share mode three
      csr_write(REG_INDEX_BITS, 32'hFFFF_FFFF);
      csr_write(REG_HISTORY_LENGTH, 32'd15);
      csr_write(REG_TAG_LENGTH, 32'd31);
      csr_write(REG_INITIAL_CTR, 32'd2);
      csr_write(REG_GLOBAL_TABLE, 32'd0);
      csr_write(REG_SHARE_MODE, 32'd3);
      directed_beats();
      random_beats(200, 1, 0);
      drain();

      // history length zero, per-entry history with a shared table
      csr_write(REG_INDEX_BITS, 32'd2);
      csr_write(REG_HISTORY_LENGTH, 32'd0);
      csr_write(REG_TAG_LENGTH, 32'd10);
      csr_write(REG_INITIAL_CTR, 32'd1);
      csr_write(REG_GLOBAL_HISTORY, 32'd0);
      csr_write(REG_GLOBAL_TABLE, 32'd1);
      csr_write(REG_SHARE_MODE, 32'(SHARE_NONE));
      directed_beats();
      random_beats(200, 1, 0);
      drain();

      // single entry, zero tag bits
      csr_write(REG_INDEX_BITS, 32'd0);
      csr_write(REG_TAG_LENGTH, 32'd0);
      csr_write(REG_INITIAL_CTR, 32'd3);
      csr_write(REG_GLOBAL_TABLE, 32'd0);
      csr_write(REG_SHARE_MODE, 32'(SHARE_PC16));
      directed_beats();
      random_beats(200, 1, 0);

      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("btb_two_level_branch_predictor regression: pass");
      else
         $display("btb_two_level_branch_predictor regression: fail");
      $finish;
   end

endmodule
